[design/assert_macros.svh]
// Assertion macros for the design files.
// No dependencies; included where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check of an implication, antecedent and consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

[design/cdll_pkg.sv]
// Shared constants and types of the circular doubly linked list engine.
// No dependencies.
package cdll_pkg;

    localparam int CAPACITY = 64;
    localparam int NODE_W   = 6;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int AMT_W    = 8;

    localparam logic [2:0] CMD_PUSH_TAIL    = 3'd0;
    localparam logic [2:0] CMD_PUSH_HEAD    = 3'd1;
    localparam logic [2:0] CMD_POP_HEAD     = 3'd2;
    localparam logic [2:0] CMD_POP_TAIL     = 3'd3;
    localparam logic [2:0] CMD_INSERT_AFTER = 3'd4;
    localparam logic [2:0] CMD_ERASE_AFTER  = 3'd5;
    localparam logic [2:0] CMD_FIND         = 3'd6;
    localparam logic [2:0] CMD_GET_NTH      = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NOTUSED  = 3'd4;

    typedef struct packed {
        logic              pop;
        logic              push;
        logic [NODE_W-1:0] slot;
    } pool_req_t;

endpackage

[design/cdll_free_pool.sv]
// Free slot stack of the list engine: stack memory plus top pointer.
// Depends on cdll_pkg.
module cdll_free_pool (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cdll_pkg::pool_req_t            req,
    output logic [cdll_pkg::NODE_W-1:0]    pop_slot,
    output logic [cdll_pkg::COUNT_W-1:0]   free_top
);

    logic [cdll_pkg::NODE_W-1:0]  stk_mem [cdll_pkg::CAPACITY];
    logic [cdll_pkg::CAPACITY-1:0] wr_valid_reg;
    logic [cdll_pkg::COUNT_W-1:0] free_top_reg;
    logic [cdll_pkg::COUNT_W-1:0] top_dec;
    logic [cdll_pkg::NODE_W-1:0]  pop_idx;
    logic [cdll_pkg::NODE_W-1:0]  mem_q_reg;
    logic [cdll_pkg::NODE_W-1:0]  dflt_q_reg;
    logic                         sel_q_reg;

    assign top_dec = free_top_reg - cdll_pkg::COUNT_W'(1);
    assign pop_idx = top_dec[cdll_pkg::NODE_W-1:0];

    // Entries never written hold their reset content: slot 0 on top.
    always_ff @(posedge aclk) begin
        if (req.push) begin
            stk_mem[free_top_reg[cdll_pkg::NODE_W-1:0]] <= req.slot;
        end
        mem_q_reg  <= stk_mem[pop_idx];
        sel_q_reg  <= wr_valid_reg[pop_idx];
        dflt_q_reg <= cdll_pkg::NODE_W'(cdll_pkg::CAPACITY - 1) - pop_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_top_reg <= cdll_pkg::COUNT_W'(cdll_pkg::CAPACITY);
            wr_valid_reg <= '0;
        end else begin
            if (req.push) begin
                free_top_reg <= free_top_reg + cdll_pkg::COUNT_W'(1);
                wr_valid_reg[free_top_reg[cdll_pkg::NODE_W-1:0]] <= 1'b1;
            end else if (req.pop) begin
                free_top_reg <= top_dec;
            end
        end
    end

    assign pop_slot = sel_q_reg ? mem_q_reg : dflt_q_reg;
    assign free_top = free_top_reg;

endmodule

[design/circular_doubly_linked_list_engine_unit.sv]
// Circular doubly linked list engine over a 64-slot node pool. One command is
// taken at a time; s_ready is low from acceptance until the result is loaded
// into the output register, and comes back with that load. An error result goes
// straight to the final state; a push on an empty list links the new node to
// itself and ends there, insert_after repeats its insertion once per copy, find
// reads once per visited node and get_nth steps once per position. Each node
// visit is one registered read of the link and key memories.
// While the receiver has not taken the previous result, the new one waits in
// the final state, so m_ready stalls delay s_ready. One result per command.
// Depends on cdll_pkg, cdll_free_pool and assert_macros.svh.
`include "assert_macros.svh"

module circular_doubly_linked_list_engine_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_command,
    input  logic signed [cdll_pkg::KEY_W-1:0]  s_value,
    input  logic [cdll_pkg::NODE_W-1:0]        s_node,
    input  logic [cdll_pkg::AMT_W-1:0]         s_amount,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [2:0]                         m_status,
    output logic [cdll_pkg::NODE_W-1:0]        m_found_node,
    output logic signed [cdll_pkg::KEY_W-1:0]  m_found_key,
    output logic [cdll_pkg::COUNT_W-1:0]       m_element_count,
    output logic [cdll_pkg::NODE_W-1:0]        m_head_node,
    output logic [cdll_pkg::NODE_W-1:0]        m_tail_node
);

    localparam int NW = cdll_pkg::NODE_W;
    localparam int KW = cdll_pkg::KEY_W;
    localparam int CW = cdll_pkg::COUNT_W;
    localparam int AW = cdll_pkg::AMT_W;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_INS_A    = 5'd2;
    localparam logic [4:0] S_INS_B    = 5'd3;
    localparam logic [4:0] S_INS_C    = 5'd4;
    localparam logic [4:0] S_TAIL_RD  = 5'd5;
    localparam logic [4:0] S_TAIL_WR  = 5'd6;
    localparam logic [4:0] S_ER_RD    = 5'd7;
    localparam logic [4:0] S_ER_V     = 5'd8;
    localparam logic [4:0] S_RM_RD    = 5'd9;
    localparam logic [4:0] S_RM_WR    = 5'd10;
    localparam logic [4:0] S_FIND_RD  = 5'd11;
    localparam logic [4:0] S_FIND_CMP = 5'd12;
    localparam logic [4:0] S_NTH      = 5'd13;
    localparam logic [4:0] S_NTH_STEP = 5'd14;
    localparam logic [4:0] S_KEY_WAIT = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    // link and key memories
    logic signed [KW-1:0] key_mem [cdll_pkg::CAPACITY];
    logic [NW-1:0]        nxt_mem [cdll_pkg::CAPACITY];
    logic [NW-1:0]        prv_mem [cdll_pkg::CAPACITY];

    logic                 key_we, nxt_we, prv_we;
    logic [NW-1:0]        key_waddr, nxt_waddr, prv_waddr;
    logic [NW-1:0]        key_raddr, nxt_raddr, prv_raddr;
    logic signed [KW-1:0] key_wdata;
    logic [NW-1:0]        nxt_wdata, prv_wdata;
    logic signed [KW-1:0] key_rdata_reg;
    logic [NW-1:0]        nxt_rdata_reg, prv_rdata_reg;

    logic [4:0]           state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic signed [KW-1:0] val_reg, val_next;
    logic [NW-1:0]        node_reg, node_next;
    logic [AW-1:0]        amt_reg, amt_next;
    logic [AW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        pos_reg, pos_next;
    logic [NW-1:0]        v_reg, v_next;
    logic [NW-1:0]        s_reg, s_next;
    logic [NW-1:0]        nx_reg, nx_next;
    logic [NW-1:0]        head_reg, head_next;
    logic [NW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [cdll_pkg::CAPACITY-1:0] in_use_reg, in_use_next;
    logic [2:0]           status_reg, status_next;
    logic [NW-1:0]        fnode_reg, fnode_next;
    logic signed [KW-1:0] fkey_reg, fkey_next;

    logic                 m_valid_reg;
    logic [2:0]           m_status_reg;
    logic [NW-1:0]        m_fnode_reg, m_head_reg, m_tail_reg;
    logic signed [KW-1:0] m_fkey_reg;
    logic [CW-1:0]        m_count_reg;

    cdll_pkg::pool_req_t  pool_req;
    logic [NW-1:0]        pool_slot;
    logic [CW-1:0]        free_top;

    cdll_free_pool u_pool (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (pool_req),
        .pop_slot (pool_slot),
        .free_top (free_top)
    );

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (nxt_we) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (prv_we) begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        key_rdata_reg <= key_mem[key_raddr];
        nxt_rdata_reg <= nxt_mem[nxt_raddr];
        prv_rdata_reg <= prv_mem[prv_raddr];
    end

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        node_next   = node_reg;
        amt_next    = amt_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        v_next      = v_reg;
        s_next      = s_reg;
        nx_next     = nx_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        in_use_next = in_use_reg;
        status_next = status_reg;
        fnode_next  = fnode_reg;
        fkey_next   = fkey_reg;
        key_we = 1'b0; key_waddr = s_reg; key_wdata = val_reg;
        nxt_we = 1'b0; nxt_waddr = s_reg; nxt_wdata = s_reg;
        prv_we = 1'b0; prv_waddr = s_reg; prv_wdata = s_reg;
        key_raddr = v_reg;
        nxt_raddr = v_reg;
        prv_raddr = v_reg;
        pool_req = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    val_next   = s_value;
                    node_next  = s_node;
                    amt_next   = s_amount;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                status_next = cdll_pkg::ST_OK;
                fnode_next  = '0;
                fkey_next   = '0;
                state_next  = S_DONE;
                unique case (cmd_reg)
                    cdll_pkg::CMD_PUSH_TAIL, cdll_pkg::CMD_PUSH_HEAD: begin
                        if (free_top == '0) begin
                            status_next = cdll_pkg::ST_FULL;
                        end else begin
                            pos_next   = tail_reg;
                            rem_next   = AW'(1);
                            state_next = S_INS_A;
                        end
                    end
                    cdll_pkg::CMD_POP_HEAD, cdll_pkg::CMD_POP_TAIL: begin
                        if (count_reg == '0) begin
                            status_next = cdll_pkg::ST_EMPTY;
                        end else begin
                            v_next = (cmd_reg == cdll_pkg::CMD_POP_HEAD) ? head_reg
                                                                         : tail_reg;
                            state_next = S_RM_RD;
                        end
                    end
                    cdll_pkg::CMD_INSERT_AFTER: begin
                        if (!in_use_reg[node_reg]) begin
                            status_next = cdll_pkg::ST_NOTUSED;
                        end else if (amt_reg > AW'(free_top)) begin
                            status_next = cdll_pkg::ST_FULL;
                        end else if (amt_reg == '0) begin
                            fnode_next = node_reg;
                            state_next = S_TAIL_RD;
                        end else begin
                            pos_next   = node_reg;
                            rem_next   = amt_reg;
                            state_next = S_INS_A;
                        end
                    end
                    cdll_pkg::CMD_ERASE_AFTER: begin
                        if (!in_use_reg[node_reg]) begin
                            status_next = cdll_pkg::ST_NOTUSED;
                        end else begin
                            state_next = S_ER_RD;
                        end
                    end
                    cdll_pkg::CMD_FIND: begin
                        if (count_reg == '0) begin
                            status_next = cdll_pkg::ST_EMPTY;
                        end else begin
                            v_next     = head_reg;
                            rem_next   = AW'(count_reg);
                            state_next = S_FIND_RD;
                        end
                    end
                    default: begin
                        if (count_reg == '0) begin
                            status_next = cdll_pkg::ST_EMPTY;
                        end else begin
                            v_next     = head_reg;
                            rem_next   = amt_reg;
                            state_next = S_NTH;
                        end
                    end
                endcase
            end
            S_INS_A: begin
                pool_req.pop = 1'b1;
                nxt_raddr    = pos_reg;
                state_next   = S_INS_B;
            end
            S_INS_B: begin
                s_next      = pool_slot;
                nx_next     = nxt_rdata_reg;
                key_we      = 1'b1;
                key_waddr   = pool_slot;
                in_use_next[pool_slot] = 1'b1;
                nxt_we      = 1'b1;
                nxt_waddr   = pool_slot;
                prv_we      = 1'b1;
                prv_waddr   = pool_slot;
                if (count_reg == '0) begin
                    // first element links to itself
                    nxt_wdata  = pool_slot;
                    prv_wdata  = pool_slot;
                    head_next  = pool_slot;
                    tail_next  = pool_slot;
                    count_next = count_reg + CW'(1);
                    fnode_next = pool_slot;
                    fkey_next  = val_reg;
                    state_next = S_DONE;
                end else begin
                    nxt_wdata  = nxt_rdata_reg;
                    prv_wdata  = pos_reg;
                    state_next = S_INS_C;
                end
            end
            S_INS_C: begin
                prv_we     = 1'b1;
                prv_waddr  = nx_reg;
                prv_wdata  = s_reg;
                nxt_we     = 1'b1;
                nxt_waddr  = pos_reg;
                nxt_wdata  = s_reg;
                count_next = count_reg + CW'(1);
                rem_next   = rem_reg - AW'(1);
                fnode_next = s_reg;
                fkey_next  = val_reg;
                priority if (cmd_reg == cdll_pkg::CMD_PUSH_TAIL) begin
                    tail_next  = s_reg;
                    state_next = S_DONE;
                end else if (cmd_reg == cdll_pkg::CMD_PUSH_HEAD) begin
                    head_next  = s_reg;
                    state_next = S_DONE;
                end else if (rem_reg == AW'(1)) begin
                    state_next = S_TAIL_RD;
                end else begin
                    state_next = S_INS_A;
                end
            end
            S_TAIL_RD: begin
                prv_raddr  = head_reg;
                key_raddr  = node_reg;
                state_next = S_TAIL_WR;
            end
            S_TAIL_WR: begin
                tail_next = prv_rdata_reg;
                if (amt_reg == '0) begin
                    fkey_next = key_rdata_reg;
                end
                state_next = S_DONE;
            end
            S_ER_RD: begin
                nxt_raddr  = node_reg;
                state_next = S_ER_V;
            end
            S_ER_V: begin
                v_next     = nxt_rdata_reg;
                state_next = S_RM_RD;
            end
            S_RM_RD: begin
                state_next = S_RM_WR;
            end
            S_RM_WR: begin
                fnode_next = v_reg;
                fkey_next  = key_rdata_reg;
                if (count_reg <= CW'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else begin
                    if (v_reg == head_reg) begin
                        head_next = nxt_rdata_reg;
                    end
                    if (v_reg == tail_reg) begin
                        tail_next = prv_rdata_reg;
                    end
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rdata_reg;
                    nxt_wdata = nxt_rdata_reg;
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata_reg;
                    prv_wdata = prv_rdata_reg;
                end
                count_next         = count_reg - CW'(1);
                in_use_next[v_reg] = 1'b0;
                pool_req.push      = 1'b1;
                pool_req.slot      = v_reg;
                state_next         = S_DONE;
            end
            S_FIND_RD: begin
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (key_rdata_reg == val_reg) begin
                    fnode_next = v_reg;
                    fkey_next  = key_rdata_reg;
                    state_next = S_DONE;
                end else if (rem_reg == AW'(1)) begin
                    status_next = cdll_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end else begin
                    v_next     = nxt_rdata_reg;
                    rem_next   = rem_reg - AW'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_NTH: begin
                state_next = (rem_reg == '0) ? S_KEY_WAIT : S_NTH_STEP;
            end
            S_NTH_STEP: begin
                v_next     = nxt_rdata_reg;
                rem_next   = rem_reg - AW'(1);
                state_next = S_NTH;
            end
            S_KEY_WAIT: begin
                fnode_next = v_reg;
                fkey_next  = key_rdata_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            in_use_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            in_use_reg <= in_use_next;
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        node_reg   <= node_next;
        amt_reg    <= amt_next;
        rem_reg    <= rem_next;
        pos_reg    <= pos_next;
        v_reg      <= v_next;
        s_reg      <= s_next;
        nx_reg     <= nx_next;
        status_reg <= status_next;
        fnode_reg  <= fnode_next;
        fkey_reg   <= fkey_next;
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_status_reg <= status_reg;
            m_fnode_reg  <= fnode_reg;
            m_fkey_reg   <= fkey_reg;
            m_count_reg  <= count_reg;
            m_head_reg   <= head_reg;
            m_tail_reg   <= tail_reg;
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found_node    = m_fnode_reg;
    assign m_found_key     = m_fkey_reg;
    assign m_element_count = m_count_reg;
    assign m_head_node     = m_head_reg;
    assign m_tail_node     = m_tail_reg;

    `ASSERT_IMPLY(a_pool_balance, aclk, aresetn, state_reg == S_IDLE, (count_reg + free_top) == CW'(cdll_pkg::CAPACITY), "element count and free slots disagree")
    `ASSERT_IMPLY(a_empty_ends, aclk, aresetn, state_reg == S_IDLE && count_reg == '0, head_reg == '0 && tail_reg == '0, "empty list with nonzero head or tail")
    `ASSERT_IMPLY(a_inuse_count, aclk, aresetn, state_reg == S_IDLE, $countones(in_use_reg) == int'(count_reg), "slot use bits disagree with count")

endmodule
